@@ rtl/core/msq_pkg.sv @@
// Package for the memory test sequencer: phase and register codes,
// pair-test patterns, and the state and result records shared by the core.
// No dependencies.
package msq_pkg;

   // Test phases, as reported on the result channel
   localparam logic [2:0] PHASE_IDLE  = 3'd0;
   localparam logic [2:0] PHASE_ONES  = 3'd1;
   localparam logic [2:0] PHASE_ZEROS = 3'd2;
   localparam logic [2:0] PHASE_PAIRS = 3'd3;
   localparam logic [2:0] PHASE_ADDR  = 3'd4;

   // Control register indexes
   localparam logic [1:0] CSR_WIDTH_MODE = 2'd0;
   localparam logic [1:0] CSR_BASE_ADDR  = 2'd1;
   localparam logic [1:0] CSR_SIZE_BYTES = 2'd2;

   // Location width codes (any other code means 16 bits)
   localparam logic [1:0] WIDTH_8  = 2'd0;
   localparam logic [1:0] WIDTH_16 = 2'd1;
   localparam logic [1:0] WIDTH_32 = 2'd2;

   // Walking bit seed and alternating patterns
   localparam logic [31:0] WALK_ONE = 32'h00000001;
   localparam logic [31:0] WALK_ZERO = 32'hfffffffe;
   localparam logic [31:0] PAT_55 = 32'h55555555;
   localparam logic [31:0] PAT_AA = 32'haaaaaaaa;
   localparam logic [31:0] PAT_66 = 32'h66666666;
   localparam logic [31:0] PAT_99 = 32'h99999999;
   localparam logic [31:0] PAT_33 = 32'h33333333;
   localparam logic [31:0] PAT_CC = 32'hcccccccc;

   // Sequencer state
   typedef struct packed {
      logic [2:0]  phase;
      logic [4:0]  bit_index;
      logic [1:0]  pair_index;
      logic        verify_pass;
      logic [31:0] location_index;
      logic        pending_check;
      logic [31:0] pending_address;
      logic [31:0] pending_expected;
   } msq_state_type;

   // One result transaction
   typedef struct packed {
      logic [31:0] mem_address;
      logic        mem_write;
      logic        mem_read;
      logic [31:0] mem_write_data;
      logic        check_error;
      logic [31:0] error_address;
      logic [31:0] found_value;
      logic [31:0] expected_value;
      logic [2:0]  test_phase;
      logic        done_res;
   } msq_result_type;

   // Pattern of a pair test; even locations take the first of the pair
   function automatic logic [31:0] pair_pattern(input logic [1:0] pair_sel,
                                                input logic odd_loc);
      logic [31:0] val;
      case (pair_sel)
         2'd0: begin
            val = odd_loc ? PAT_AA : PAT_55;
         end
         2'd1: begin
            val = odd_loc ? PAT_99 : PAT_66;
         end
         default: begin
            val = odd_loc ? PAT_CC : PAT_33;
         end
      endcase
      return val;
   endfunction

   // Walking bit patterns at a bit position
   function automatic logic [31:0] walk_one(input logic [4:0] bit_pos);
      return WALK_ONE << bit_pos;
   endfunction

   function automatic logic [31:0] walk_zero(input logic [4:0] bit_pos);
      return ~(~WALK_ZERO << bit_pos);
   endfunction

endpackage

@@ rtl/core/msq_step.sv @@
// Next-step logic of the memory test sequencer: read-back check, pass
// advance with empty-pass skipping, and the access for one transaction.
// Depends on msq_pkg.
module msq_step #(
   parameter int ADDR_BITS = 32,
   parameter int DATA_BITS = 32
) (
   input  msq_pkg::msq_state_type  cur_state,
   input  logic [1:0]              width_mode,
   input  logic [31:0]             base_address,
   input  logic [31:0]             size_bytes,
   input  logic                    start_req,
   input  logic [31:0]             read_data,
   output msq_pkg::msq_state_type  next_state,
   output msq_pkg::msq_result_type result
);

   localparam int ADDR_KEEP = (ADDR_BITS < 32) ? ADDR_BITS : 32;
   localparam logic [31:0] ADDR_MASK = 32'hffffffff >> (32 - ADDR_KEEP);
   localparam logic [31:0] DATA_MASK = 32'hffffffff >> (32 - DATA_BITS);

   logic [1:0]  loc_shift;
   logic [5:0]  loc_bits;
   logic [31:0] data_mask;
   logic [31:0] loc_count;
   logic [31:0] pair_count;
   logic [31:0] found;

   msq_pkg::msq_state_type s0;
   msq_pkg::msq_state_type s1;
   msq_pkg::msq_state_type s_iss;

   logic        active0;
   logic        issue_now;
   logic        done1;
   logic [4:0]  bit_inc;
   logic [1:0]  pair_inc;
   logic [31:0] count1;
   logic        issue;
   logic        done;

   logic [33:0] loc_offset;
   logic [34:0] addr_sum;
   logic [31:0] addr;
   logic [31:0] pattern;

   // Location geometry from the width register
   always_comb begin
      case (width_mode)
         msq_pkg::WIDTH_8: begin
            loc_shift = 2'd0;
            loc_bits  = 6'd8;
            data_mask = 32'h000000ff & DATA_MASK;
         end
         msq_pkg::WIDTH_32: begin
            loc_shift = 2'd2;
            loc_bits  = 6'd32;
            data_mask = 32'hffffffff & DATA_MASK;
         end
         default: begin
            loc_shift = 2'd1;
            loc_bits  = 6'd16;
            data_mask = 32'h0000ffff & DATA_MASK;
         end
      endcase
      loc_count  = size_bytes >> loc_shift;
      pair_count = {loc_count[31:1], 1'b0};
   end

   // Start or read-back check, then pass advance
   always_comb begin
      s0     = cur_state;
      result = '0;
      found  = read_data & data_mask;

      if (start_req) begin
         s0.phase          = msq_pkg::PHASE_ONES;
         s0.bit_index      = 5'd0;
         s0.pair_index     = 2'd0;
         s0.verify_pass    = 1'b0;
         s0.location_index = 32'd0;
      end else if (cur_state.pending_check && (found != cur_state.pending_expected)) begin
         result.check_error    = 1'b1;
         result.error_address  = cur_state.pending_address;
         result.found_value    = found;
         result.expected_value = cur_state.pending_expected;
      end
      s0.pending_check = 1'b0;

      active0 = (s0.phase != msq_pkg::PHASE_IDLE) && (s0.phase <= msq_pkg::PHASE_ADDR);
      issue_now = active0 && (s0.location_index <
                  ((s0.phase == msq_pkg::PHASE_PAIRS) ? pair_count : loc_count));

      // Next pass after the current one ran out
      s1                = s0;
      s1.location_index = 32'd0;
      done1             = 1'b0;
      bit_inc           = s0.bit_index + 5'd1;
      pair_inc          = s0.pair_index + 2'd1;
      if (!s0.verify_pass) begin
         s1.verify_pass = 1'b1;
      end else begin
         s1.verify_pass = 1'b0;
         case (s0.phase)
            msq_pkg::PHASE_ONES, msq_pkg::PHASE_ZEROS: begin
               if ((bit_inc == 5'd0) || ({1'b0, bit_inc} >= loc_bits)) begin
                  s1.bit_index = 5'd0;
                  s1.phase     = s0.phase + 3'd1;
               end else begin
                  s1.bit_index = bit_inc;
               end
            end
            msq_pkg::PHASE_PAIRS: begin
               if (pair_inc == 2'd3) begin
                  s1.pair_index = 2'd0;
                  s1.phase      = msq_pkg::PHASE_ADDR;
               end else begin
                  s1.pair_index = pair_inc;
               end
            end
            default: begin
               s1.phase = msq_pkg::PHASE_IDLE;
               done1    = 1'b1;
            end
         endcase
      end
      count1 = (s1.phase == msq_pkg::PHASE_PAIRS) ? pair_count : loc_count;

      // Pick the state that issues this step; an empty phase is skipped whole
      s_iss = s0;
      issue = 1'b0;
      done  = 1'b0;
      if (!active0) begin
         s_iss.phase = msq_pkg::PHASE_IDLE;
      end else if (issue_now) begin
         issue = 1'b1;
      end else if (done1) begin
         s_iss = s1;
         done  = 1'b1;
      end else if (count1 != 32'd0) begin
         s_iss = s1;
         issue = 1'b1;
      end else if ((s1.phase == msq_pkg::PHASE_PAIRS) && (loc_count != 32'd0)) begin
         s_iss             = s1;
         s_iss.phase       = msq_pkg::PHASE_ADDR;
         s_iss.bit_index   = 5'd0;
         s_iss.pair_index  = 2'd0;
         s_iss.verify_pass = 1'b0;
         issue             = 1'b1;
      end else begin
         s_iss       = s1;
         s_iss.phase = msq_pkg::PHASE_IDLE;
         done        = 1'b1;
      end

      // Access address and pattern for the issuing location
      loc_offset = {2'b00, s_iss.location_index} << loc_shift;
      addr_sum   = {3'b000, base_address} + {1'b0, loc_offset};
      addr       = addr_sum[31:0] & ADDR_MASK;
      case (s_iss.phase)
         msq_pkg::PHASE_ONES: begin
            pattern = msq_pkg::walk_one(s_iss.bit_index) & data_mask;
         end
         msq_pkg::PHASE_ZEROS: begin
            pattern = msq_pkg::walk_zero(s_iss.bit_index) & data_mask;
         end
         msq_pkg::PHASE_PAIRS: begin
            pattern = msq_pkg::pair_pattern(s_iss.pair_index, s_iss.location_index[0])
                      & data_mask;
         end
         default: begin
            pattern = addr & data_mask;
         end
      endcase

      next_state = s_iss;
      if (issue) begin
         next_state.location_index = s_iss.location_index + 32'd1;
         result.mem_address        = addr;
         if (s_iss.verify_pass) begin
            result.mem_read             = 1'b1;
            next_state.pending_check    = 1'b1;
            next_state.pending_address  = addr;
            next_state.pending_expected = pattern;
         end else begin
            result.mem_write      = 1'b1;
            result.mem_write_data = pattern;
         end
      end
      result.done_res   = done;
      result.test_phase = next_state.phase;
   end

endmodule

@@ rtl/core/memory_test_sequencer.sv @@
// Memory self-test sequencer. Each accepted request transaction produces
// exactly one response transaction, registered and valid the cycle after
// acceptance; a new request is taken every cycle while the response register
// is empty or being drained, so the block sustains one memory access per
// clock. The step path is one location compare, one address add and the
// pattern select. A start transaction runs walking ones, walking zeros, the
// 55/AA, 66/99 and 33/CC pairs and address-in-address, each as a write pass
// then a verify pass; read data for a verify read comes back on the next
// request and any mismatch is reported on its response. Control registers:
// 0 width mode, 1 base address, 2 size in bytes; write them only while idle.
// Depends on msq_pkg and msq_step.
module memory_test_sequencer #(
   parameter int ADDR_BITS = 32,
   parameter int DATA_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_start_req,
   input  logic [31:0] req_read_data,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_mem_address,
   output logic        rsp_mem_write,
   output logic        rsp_mem_read,
   output logic [31:0] rsp_mem_write_data,
   output logic        rsp_check_error,
   output logic [31:0] rsp_error_address,
   output logic [31:0] rsp_found_value,
   output logic [31:0] rsp_expected_value,
   output logic [2:0]  rsp_test_phase,
   output logic        rsp_done_res
);

   logic [1:0]  width_mode_ff;
   logic [31:0] base_address_ff;
   logic [31:0] size_bytes_ff;

   msq_pkg::msq_state_type  state_ff;
   msq_pkg::msq_state_type  state_in;
   msq_pkg::msq_result_type rsp_ff;
   msq_pkg::msq_result_type rsp_in;
   logic                    rsp_valid_ff;
   logic                    req_fire;

   // Control register writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_mode_ff   <= msq_pkg::WIDTH_16;
         base_address_ff <= 32'd0;
         size_bytes_ff   <= 32'd0;
      end else if (csr_valid) begin
         case (csr_index)
            msq_pkg::CSR_WIDTH_MODE: width_mode_ff   <= csr_data[1:0];
            msq_pkg::CSR_BASE_ADDR:  base_address_ff <= csr_data;
            msq_pkg::CSR_SIZE_BYTES: size_bytes_ff   <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Step logic
   msq_step #(
      .ADDR_BITS (ADDR_BITS),
      .DATA_BITS (DATA_BITS)
   ) u_step (
      .cur_state    (state_ff),
      .width_mode   (width_mode_ff),
      .base_address (base_address_ff),
      .size_bytes   (size_bytes_ff),
      .start_req    (req_start_req),
      .read_data    (req_read_data),
      .next_state   (state_in),
      .result       (rsp_in)
   );

   // Accept while the response register is free or draining
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (req_fire) begin
         state_ff <= state_in;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_mem_address    = rsp_ff.mem_address;
   assign rsp_mem_write      = rsp_ff.mem_write;
   assign rsp_mem_read       = rsp_ff.mem_read;
   assign rsp_mem_write_data = rsp_ff.mem_write_data;
   assign rsp_check_error    = rsp_ff.check_error;
   assign rsp_error_address  = rsp_ff.error_address;
   assign rsp_found_value    = rsp_ff.found_value;
   assign rsp_expected_value = rsp_ff.expected_value;
   assign rsp_test_phase     = rsp_ff.test_phase;
   assign rsp_done_res       = rsp_ff.done_res;

`ifndef ASSERT_OFF
   // Finishing the sequence leaves the sequencer idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire && rsp_in.done_res |=> state_ff.phase == msq_pkg::PHASE_IDLE)
      else $error("sequencer not idle after done");

   // A mismatch is only reported when a read was outstanding
   a_error_needs_read: assert property (@(posedge clock) disable iff (reset)
      req_fire && !state_ff.pending_check |=> !rsp_ff.check_error)
      else $error("check error without outstanding read");

   // Every issued read leaves a check pending for the next transaction
   a_read_pending: assert property (@(posedge clock) disable iff (reset)
      req_fire && rsp_in.mem_read |=> state_ff.pending_check)
      else $error("read issued without pending check");
`endif

endmodule

@@ tb/msq_access_checker.sv @@
// Access checker for the memory test sequencer: tracks control writes and
// request transactions, predicts every response transaction and compares it.
// Depends on msq_pkg.
module msq_access_checker (
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data,

   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_start_req,
   input  logic [31:0] req_read_data,

   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_mem_address,
   input  logic        rsp_mem_write,
   input  logic        rsp_mem_read,
   input  logic [31:0] rsp_mem_write_data,
   input  logic        rsp_check_error,
   input  logic [31:0] rsp_error_address,
   input  logic [31:0] rsp_found_value,
   input  logic [31:0] rsp_expected_value,
   input  logic [2:0]  rsp_test_phase,
   input  logic        rsp_done_res,

   output int          error_count,
   output int          pending_count
);

   // Shadow copy of the control registers
   logic [1:0]  cfg_width;
   logic [31:0] cfg_base;
   logic [31:0] cfg_size;

   // Shadow copy of the sequencer state
   logic [2:0]  seq_phase;
   logic [4:0]  seq_bit;
   logic [1:0]  seq_pair;
   logic        seq_verify;
   logic [31:0] seq_loc;
   logic        rd_pending;
   logic [31:0] rd_addr;
   logic [31:0] rd_expected;

   // Responses predicted but not yet seen, oldest first
   msq_pkg::msq_result_type predicted_steps[$];
   msq_pkg::msq_result_type seen_step;
   msq_pkg::msq_result_type want_step;

   // log2 of the location size in bytes; code 3 acts as 16 bits
   function automatic int loc_shift();
      case (cfg_width)
         msq_pkg::WIDTH_8: begin
            return 0;
         end
         msq_pkg::WIDTH_32: begin
            return 2;
         end
         default: begin
            return 1;
         end
      endcase
   endfunction

   function automatic int loc_bits();
      return 8 << loc_shift();
   endfunction

   function automatic logic [31:0] loc_mask();
      if (loc_shift() == 2) begin
         return 32'hffffffff;
      end
      return (32'd1 << loc_bits()) - 32'd1;
   endfunction

   // Locations in the current pass; pair tests use an even count
   function automatic logic [31:0] pass_locations();
      logic [31:0] n;
      n = cfg_size >> loc_shift();
      if (seq_phase == msq_pkg::PHASE_PAIRS) begin
         n[0] = 1'b0;
      end
      return n;
   endfunction

   function automatic logic [31:0] location_pattern(input logic [31:0] idx,
                                                    input logic [31:0] addr);
      logic [31:0] val;
      logic [1:0]  k;
      case (seq_phase)
         msq_pkg::PHASE_ONES: begin
            val = 32'd1 << seq_bit;
         end
         msq_pkg::PHASE_ZEROS: begin
            val = ~(32'd1 << seq_bit);
         end
         msq_pkg::PHASE_PAIRS: begin
            k = (seq_pair < 2'd3) ? seq_pair : 2'd2;
            case ({k, idx[0]})
               3'b000: val = msq_pkg::PAT_55;
               3'b001: val = msq_pkg::PAT_AA;
               3'b010: val = msq_pkg::PAT_66;
               3'b011: val = msq_pkg::PAT_99;
               3'b100: val = msq_pkg::PAT_33;
               default: val = msq_pkg::PAT_CC;
            endcase
         end
         default: begin
            val = addr;
         end
      endcase
      return val & loc_mask();
   endfunction

   // Step to the next pass; returns 1 once the last pass is over
   function automatic bit advance_pass();
      seq_loc = '0;
      if (!seq_verify) begin
         seq_verify = 1'b1;
         return 1'b0;
      end
      seq_verify = 1'b0;
      if (seq_phase == msq_pkg::PHASE_ONES || seq_phase == msq_pkg::PHASE_ZEROS) begin
         seq_bit = seq_bit + 5'd1;
         if (seq_bit == 5'd0 || seq_bit >= loc_bits()) begin
            seq_bit = '0;
            seq_phase = seq_phase + 3'd1;
         end
      end else if (seq_phase == msq_pkg::PHASE_PAIRS) begin
         seq_pair = seq_pair + 2'd1;
         if (seq_pair >= 2'd3) begin
            seq_pair = '0;
            seq_phase = msq_pkg::PHASE_ADDR;
         end
      end else begin
         seq_phase = msq_pkg::PHASE_IDLE;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // One request transaction: check the outstanding read, issue one access
   function automatic msq_pkg::msq_result_type advance_sequencer(input logic start,
                                                                 input logic [31:0] rdata);
      msq_pkg::msq_result_type res;
      logic [31:0]             found;
      logic [31:0]             addr;
      logic [31:0]             val;
      bit                      stepping;
      res = '0;
      if (start) begin
         seq_phase = msq_pkg::PHASE_ONES;
         seq_bit = '0;
         seq_pair = '0;
         seq_verify = 1'b0;
         seq_loc = '0;
         rd_pending = 1'b0;
      end else if (rd_pending) begin
         found = rdata & loc_mask();
         if (found != rd_expected) begin
            res.check_error = 1'b1;
            res.error_address = rd_addr;
            res.found_value = found;
            res.expected_value = rd_expected;
         end
         rd_pending = 1'b0;
      end
      // empty passes are skipped within the same step
      stepping = 1'b1;
      while (stepping && seq_phase != msq_pkg::PHASE_IDLE &&
             seq_phase <= msq_pkg::PHASE_ADDR) begin
         if (seq_loc < pass_locations()) begin
            addr = cfg_base + (seq_loc << loc_shift());
            val = location_pattern(seq_loc, addr);
            res.mem_address = addr;
            if (seq_verify) begin
               res.mem_read = 1'b1;
               rd_pending = 1'b1;
               rd_addr = addr;
               rd_expected = val;
            end else begin
               res.mem_write = 1'b1;
               res.mem_write_data = val;
            end
            seq_loc = seq_loc + 32'd1;
            stepping = 1'b0;
         end else if (advance_pass()) begin
            res.done_res = 1'b1;
            stepping = 1'b0;
         end
      end
      res.test_phase = seq_phase;
      return res;
   endfunction

   function automatic int check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
         return 1;
      end
      return 0;
   endfunction

   // Compare responses first, then take control writes and new requests
   always @(posedge clock) begin
      if (reset) begin
         cfg_width = msq_pkg::WIDTH_16;
         cfg_base = '0;
         cfg_size = '0;
         seq_phase = msq_pkg::PHASE_IDLE;
         seq_bit = '0;
         seq_pair = '0;
         seq_verify = 1'b0;
         seq_loc = '0;
         rd_pending = 1'b0;
         rd_addr = '0;
         rd_expected = '0;
         predicted_steps.delete();
         error_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen_step.mem_address = rsp_mem_address;
            seen_step.mem_write = rsp_mem_write;
            seen_step.mem_read = rsp_mem_read;
            seen_step.mem_write_data = rsp_mem_write_data;
            seen_step.check_error = rsp_check_error;
            seen_step.error_address = rsp_error_address;
            seen_step.found_value = rsp_found_value;
            seen_step.expected_value = rsp_expected_value;
            seen_step.test_phase = rsp_test_phase;
            seen_step.done_res = rsp_done_res;
            if (predicted_steps.size() == 0) begin
               $display("%0t: unexpected response: expected none, actual %h",
                        $time, seen_step);
               error_count++;
            end else begin
               want_step = predicted_steps.pop_front();
               error_count += check_field("mem_address", want_step.mem_address,
                                          seen_step.mem_address);
               error_count += check_field("mem_write", want_step.mem_write,
                                          seen_step.mem_write);
               error_count += check_field("mem_read", want_step.mem_read,
                                          seen_step.mem_read);
               error_count += check_field("mem_write_data", want_step.mem_write_data,
                                          seen_step.mem_write_data);
               error_count += check_field("check_error", want_step.check_error,
                                          seen_step.check_error);
               error_count += check_field("error_address", want_step.error_address,
                                          seen_step.error_address);
               error_count += check_field("found_value", want_step.found_value,
                                          seen_step.found_value);
               error_count += check_field("expected_value", want_step.expected_value,
                                          seen_step.expected_value);
               error_count += check_field("test_phase", want_step.test_phase,
                                          seen_step.test_phase);
               error_count += check_field("done_res", want_step.done_res,
                                          seen_step.done_res);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               msq_pkg::CSR_WIDTH_MODE: begin
                  cfg_width = csr_data[1:0];
               end
               msq_pkg::CSR_BASE_ADDR: begin
                  cfg_base = csr_data;
               end
               msq_pkg::CSR_SIZE_BYTES: begin
                  cfg_size = csr_data;
               end
               default: begin
               end
            endcase
         end
         if (req_valid && req_ready) begin
            predicted_steps.push_back(advance_sequencer(req_start_req, req_read_data));
         end
      end
      pending_count = predicted_steps.size();
   end

endmodule

@@ tb/tb_memory_test_sequencer.sv @@
// Top of the memory test sequencer testbench: clock, reset, control writes,
// request and response traffic with a small memory image, and the verdict.
// Depends on msq_pkg, memory_test_sequencer and msq_access_checker.
module tb_memory_test_sequencer;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int RANDOM_ITEMS   = 1250;
   localparam int HOLD_CYCLES    = 60;
   localparam int TICK_CAP       = 1000;

   logic        clock;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [31:0] csr_data;
   logic        req_valid;
   logic        req_ready;
   logic        req_start_req;
   logic [31:0] req_read_data;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_mem_address;
   logic        rsp_mem_write;
   logic        rsp_mem_read;
   logic [31:0] rsp_mem_write_data;
   logic        rsp_check_error;
   logic [31:0] rsp_error_address;
   logic [31:0] rsp_found_value;
   logic [31:0] rsp_expected_value;
   logic [2:0]  rsp_test_phase;
   logic        rsp_done_res;

   int check_failures;
   int results_pending;

   // Traffic bookkeeping and the memory image built from write responses
   int          req_count;
   int          rsp_count;
   int          last_start_idx;
   bit          seq_finished;
   logic [31:0] last_rsp_addr;
   bit          last_rsp_read;
   logic [31:0] mem_image [logic [31:0]];

   int snd_idle_pct;
   int rcv_idle_pct;
   int live_items;
   bit hold_request;
   int hold_left;
   int idle_cycles;

   memory_test_sequencer u_top (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_start_req      (req_start_req),
      .req_read_data      (req_read_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_mem_address    (rsp_mem_address),
      .rsp_mem_write      (rsp_mem_write),
      .rsp_mem_read       (rsp_mem_read),
      .rsp_mem_write_data (rsp_mem_write_data),
      .rsp_check_error    (rsp_check_error),
      .rsp_error_address  (rsp_error_address),
      .rsp_found_value    (rsp_found_value),
      .rsp_expected_value (rsp_expected_value),
      .rsp_test_phase     (rsp_test_phase),
      .rsp_done_res       (rsp_done_res)
   );

   msq_access_checker u_access_check (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_start_req      (req_start_req),
      .req_read_data      (req_read_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_mem_address    (rsp_mem_address),
      .rsp_mem_write      (rsp_mem_write),
      .rsp_mem_read       (rsp_mem_read),
      .rsp_mem_write_data (rsp_mem_write_data),
      .rsp_check_error    (rsp_check_error),
      .rsp_error_address  (rsp_error_address),
      .rsp_found_value    (rsp_found_value),
      .rsp_expected_value (rsp_expected_value),
      .rsp_test_phase     (rsp_test_phase),
      .rsp_done_res       (rsp_done_res),
      .error_count        (check_failures),
      .pending_count      (results_pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Response transactions update the memory image; a done that follows
   // the latest start ends the running sequence
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (rsp_mem_write) begin
               mem_image[rsp_mem_address] = rsp_mem_write_data;
            end
            last_rsp_addr = rsp_mem_address;
            last_rsp_read = rsp_mem_read;
            if (rsp_done_res && rsp_count >= last_start_idx) begin
               seq_finished = 1'b1;
            end
            rsp_count++;
         end
         if (req_valid && req_ready) begin
            if (req_start_req) begin
               last_start_idx = req_count;
               seq_finished = 1'b0;
            end
            req_count++;
         end
      end
   end

   // Watchdog: too many cycles without any transaction
   initial begin
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("memory_test_sequencer verification failed");
      $finish;
   end

   // Receiver: random stalls, plus a long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
         end
      end
   end

   // Read data for the read issued by the latest request: taken from the
   // memory image when that response is known, else random; sometimes damaged
   function automatic logic [31:0] pick_read_data();
      logic [31:0] src_addr;
      logic [31:0] val;
      bit          src_read;
      int          roll;
      src_addr = '0;
      src_read = 1'b0;
      if (rsp_count == req_count) begin
         src_addr = last_rsp_addr;
         src_read = last_rsp_read;
      end else if (rsp_valid && rsp_count + 1 == req_count) begin
         src_addr = rsp_mem_address;
         src_read = rsp_mem_read;
      end
      if (src_read && mem_image.exists(src_addr)) begin
         val = mem_image[src_addr];
      end else begin
         val = $urandom;
      end
      roll = $urandom_range(99);
      if (roll < 8) begin
         val ^= 32'd1 << $urandom_range(31);
      end else if (roll < 12) begin
         val = $urandom;
      end
      return val;
   endfunction

   // One request transaction; entered and left at a falling edge
   task automatic send_item(input bit start, input bit use_fixed,
                            input logic [31:0] fixed_data);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      if (start || !seq_finished) begin
         live_items++;
      end
      req_valid <= 1'b1;
      req_start_req <= start;
      req_read_data <= use_fixed ? fixed_data : pick_read_data();
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   // Stop sending and wait for every predicted response
   task automatic settle();
      req_valid <= 1'b0;
      do begin
         @(negedge clock);
      end while (results_pending != 0);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Ticks until the sequence ends, with an optional restart part way
   task automatic finish_sequence();
      int ticks;
      int restart_at;
      restart_at = ($urandom_range(99) < 15) ? $urandom_range(40, 1) : -1;
      ticks = 0;
      while (!seq_finished && ticks < TICK_CAP) begin
         send_item(ticks == restart_at, 1'b0, '0);
         ticks++;
      end
   endtask

   task automatic random_segment(input bit pressure);
      int          width;
      int          shift;
      int          locs;
      int          roll;
      logic [31:0] base;
      logic [31:0] size;
      logic [31:0] mode_word;
      width = $urandom_range(3);
      shift = (width == 0) ? 0 : ((width == 2) ? 2 : 1);
      roll = $urandom_range(9);
      base = (roll == 0) ? 32'h0 : (roll == 1) ? 32'hffffffff :
             (roll == 2) ? 32'hfffffffc : $urandom;
      roll = $urandom_range(99);
      locs = (roll < 10) ? 0 : (roll < 55) ? 1 : (roll < 90) ? 2 : 3;
      if (shift == 2 && locs > 2) begin
         locs = 2;
      end
      size = (locs << shift) | $urandom_range((1 << shift) - 1);
      // upper bits of the width word are don't-care
      mode_word = $urandom;
      mode_word[1:0] = width[1:0];
      write_csr(msq_pkg::CSR_WIDTH_MODE, mode_word);
      write_csr(msq_pkg::CSR_BASE_ADDR, base);
      write_csr(msq_pkg::CSR_SIZE_BYTES, size);
      if (pressure) begin
         hold_request = 1'b1;
      end
      send_item(1'b1, 1'b0, '0);
      finish_sequence();
      // a few ticks while idle
      repeat ($urandom_range(2)) begin
         send_item(1'b0, 1'b0, '0);
      end
      settle();
   endtask

   initial begin
      bit pressed;
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_valid = 1'b0;
      req_start_req = 1'b0;
      req_read_data = '0;
      req_count = 0;
      rsp_count = 0;
      last_start_idx = 0;
      seq_finished = 1'b1;
      last_rsp_addr = '0;
      last_rsp_read = 1'b0;
      hold_request = 1'b0;
      live_items = 0;
      snd_idle_pct = 10;
      rcv_idle_pct = 85;
      pressed = 1'b0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: tick while idle, then starts whose passes are all empty
      send_item(1'b0, 1'b1, 32'hffffffff);
      send_item(1'b1, 1'b1, 32'h0);
      settle();
      write_csr(msq_pkg::CSR_WIDTH_MODE, 32'hffffffff);
      write_csr(msq_pkg::CSR_SIZE_BYTES, 32'd1);
      send_item(1'b1, 1'b1, 32'h0);
      settle();
      write_csr(msq_pkg::CSR_WIDTH_MODE, {30'd0, msq_pkg::WIDTH_32});
      write_csr(msq_pkg::CSR_SIZE_BYTES, 32'd3);
      send_item(1'b1, 1'b1, 32'hffffffff);
      settle();

      // Directed: 8-bit locations wrapping past the top of the address space;
      // masked match, mismatch, then a restart that drops an outstanding read
      write_csr(msq_pkg::CSR_WIDTH_MODE, {30'd0, msq_pkg::WIDTH_8});
      write_csr(msq_pkg::CSR_BASE_ADDR, 32'hffffffff);
      write_csr(msq_pkg::CSR_SIZE_BYTES, 32'd3);
      send_item(1'b1, 1'b1, 32'h0);
      send_item(1'b0, 1'b1, 32'h0);
      send_item(1'b0, 1'b1, 32'hffffffff);
      send_item(1'b0, 1'b1, 32'h0);
      send_item(1'b0, 1'b1, 32'hffffff01);
      send_item(1'b0, 1'b1, 32'h0);
      send_item(1'b1, 1'b1, 32'hffffffff);
      finish_sequence();
      settle();

      // Random sequences under three idling schedules
      while (live_items < RANDOM_ITEMS) begin
         if (live_items < RANDOM_ITEMS / 3) begin
            snd_idle_pct = 10;
            rcv_idle_pct = 85;
         end else if (live_items < 2 * RANDOM_ITEMS / 3) begin
            snd_idle_pct = 85;
            rcv_idle_pct = 10;
         end else begin
            snd_idle_pct = 0;
            rcv_idle_pct = 0;
         end
         random_segment((rcv_idle_pct == 0 && !pressed) || $urandom_range(99) < 8);
         if (rcv_idle_pct == 0) begin
            pressed = 1'b1;
         end
      end

      // Largest region with 32-bit locations at the top of the address space;
      // it never finishes, so it comes last, with a restart and a hold-off
      write_csr(msq_pkg::CSR_WIDTH_MODE, {30'd0, msq_pkg::WIDTH_32});
      write_csr(msq_pkg::CSR_BASE_ADDR, 32'hfffffffc);
      write_csr(msq_pkg::CSR_SIZE_BYTES, 32'hffffffff);
      hold_request = 1'b1;
      send_item(1'b1, 1'b0, '0);
      repeat (30) send_item(1'b0, 1'b0, '0);
      send_item(1'b1, 1'b0, '0);
      repeat (20) send_item(1'b0, 1'b0, '0);

      settle();
      repeat (5) @(negedge clock);
      if (check_failures == 0) begin
         $display("memory_test_sequencer verification clean");
      end else begin
         $display("memory_test_sequencer verification failed");
      end
      $finish;
   end

endmodule
